// File: design/tfn_pkg.sv
// Shared constants and types for the triangle face normal pipeline.
package tfn_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAG_W           = 30;
	localparam int SQR_W           = 2 * MAG_W;
	localparam int SUM_W           = SQR_W + 2;
	localparam int LEN_W           = SUM_W / 2;
	localparam int ROOT_STEPS      = 32;
	localparam int ROOT_W          = 64;
	localparam int Q_W             = 15;
	localparam int NUM_W           = MAG_W + Q_W;
	localparam int OUT_W           = 16;
	localparam int NORM_SHIFT      = MAG_W - 1;
	localparam logic [Q_W-1:0] UNIT_Q14 = Q_W'(16384);

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
		logic                  last;
	} side_t;

endpackage

// File: design/tfn_front.sv
// Edge vectors, cross product, block scaling and squared length.
module tfn_front #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [9*COORD_WIDTH-1:0]   in_data,
	input  logic                       in_last,
	output logic                       out_valid,
	output logic [tfn_pkg::SUM_W-1:0]  out_sum,
	output tfn_pkg::side_t             out_side
);

	localparam int IW  = (COORD_WIDTH > 30) ? 30 : COORD_WIDTH;
	localparam int ESH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
	localparam int EW  = IW + 1;
	localparam int PW  = 2 * EW;
	localparam int NW  = 2 * EW;
	localparam int LZW = $clog2(NW);
	localparam int MW  = tfn_pkg::MAG_W;

	function automatic logic signed [EW-1:0] trim(input logic signed [COORD_WIDTH:0] d);
		logic signed [COORD_WIDTH:0] a;
		a = (d < 0) ? -d : d;
		a = a >>> ESH;
		if (d < 0) begin
			a = -a;
		end
		return a[EW-1:0];
	endfunction

	function automatic logic [LZW-1:0] top_bit(input logic [NW-1:0] v);
		logic [LZW-1:0] p;
		p = '0;
		for (int i = 0; i < NW; i++) begin
			if (v[i]) begin
				p = LZW'(i);
			end
		end
		return p;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6;
	logic signed [EW-1:0] e0_s1 [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [PW-1:0] pr_s2 [6];
	logic [NW-1:0]        m_s3 [3];
	logic [2:0]           neg_s3, neg_s4, neg_s5, neg_s6;
	logic [NW-1:0]        or_s3;
	logic [NW-1:0]        m_s4 [3];
	logic [LZW-1:0]       pos_s4;
	logic                 dg_s4, dg_s5, dg_s6;
	logic [MW-1:0]        m_s5 [3];
	logic [MW-1:0]        m_s6 [3];
	logic [tfn_pkg::SQR_W-1:0] sq_s6 [3];
	logic [tfn_pkg::SUM_W-1:0] sum_s7;
	tfn_pkg::side_t       side_s7;

	logic signed [EW-1:0] e0_c [3];
	logic signed [EW-1:0] e1_c [3];
	logic [NW-1:0]        m_c [3];
	logic [2:0]           neg_c;
	logic [MW-1:0]        sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e0_c[i] = trim(
				$signed({in_data[(i+1)*COORD_WIDTH-1], in_data[i*COORD_WIDTH +: COORD_WIDTH]}) -
				$signed({in_data[(i+4)*COORD_WIDTH-1], in_data[(i+3)*COORD_WIDTH +: COORD_WIDTH]}));
			e1_c[i] = trim(
				$signed({in_data[(i+4)*COORD_WIDTH-1], in_data[(i+3)*COORD_WIDTH +: COORD_WIDTH]}) -
				$signed({in_data[(i+7)*COORD_WIDTH-1], in_data[(i+6)*COORD_WIDTH +: COORD_WIDTH]}));
		end
	end

	always_comb begin
		logic signed [PW:0] n;
		for (int i = 0; i < 3; i++) begin
			n = $signed({pr_s2[2*i][PW-1], pr_s2[2*i]}) -
				$signed({pr_s2[2*i+1][PW-1], pr_s2[2*i+1]});
			neg_c[i] = n[PW];
			m_c[i] = n[PW] ? NW'(-n) : NW'(n);
		end
	end

	always_comb begin
		logic [NW+tfn_pkg::NORM_SHIFT-1:0] w;
		for (int i = 0; i < 3; i++) begin
			w = {m_s4[i], {tfn_pkg::NORM_SHIFT{1'b0}}} >> pos_s4;
			sh_c[i] = w[MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1 <= in_last;
			e0_s1 <= e0_c;
			e1_s1 <= e1_c;

			l_s2 <= l_s1;
			pr_s2[0] <= e0_s1[1] * e1_s1[2];
			pr_s2[1] <= e0_s1[2] * e1_s1[1];
			pr_s2[2] <= e0_s1[2] * e1_s1[0];
			pr_s2[3] <= e0_s1[0] * e1_s1[2];
			pr_s2[4] <= e0_s1[0] * e1_s1[1];
			pr_s2[5] <= e0_s1[1] * e1_s1[0];

			l_s3 <= l_s2;
			m_s3 <= m_c;
			neg_s3 <= neg_c;
			or_s3 <= m_c[0] | m_c[1] | m_c[2];

			l_s4 <= l_s3;
			m_s4 <= m_s3;
			neg_s4 <= neg_s3;
			pos_s4 <= top_bit(or_s3);
			dg_s4 <= (or_s3 == '0);

			l_s5 <= l_s4;
			m_s5 <= sh_c;
			neg_s5 <= neg_s4;
			dg_s5 <= dg_s4;

			l_s6 <= l_s5;
			m_s6 <= m_s5;
			neg_s6 <= neg_s5;
			dg_s6 <= dg_s5;
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= m_s5[i] * m_s5[i];
			end

			sum_s7 <= tfn_pkg::SUM_W'(sq_s6[0]) + tfn_pkg::SUM_W'(sq_s6[1]) +
				tfn_pkg::SUM_W'(sq_s6[2]);
			side_s7.mag <= {m_s6[2], m_s6[1], m_s6[0]};
			side_s7.neg <= neg_s6;
			side_s7.degen <= dg_s6;
			side_s7.last <= l_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_sum   = sum_s7;
	assign out_side  = side_s7;

endmodule

// File: design/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [tfn_pkg::SUM_W-1:0]  in_sum,
	input  tfn_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [tfn_pkg::LEN_W-1:0]  out_len,
	output tfn_pkg::side_t             out_side
);

	localparam int N  = tfn_pkg::ROOT_STEPS;
	localparam int RW = tfn_pkg::ROOT_W;

	logic [N:0]     v_q;
	logic [RW-1:0]  x_q [N+1];
	logic [RW-1:0]  r_q [N+1];
	tfn_pkg::side_t sd_q [N+1];

	always_comb begin
		v_q[0]  = in_valid;
		x_q[0]  = RW'(in_sum);
		r_q[0]  = '0;
		sd_q[0] = in_side;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
		logic [RW-1:0] t;
		assign t = r_q[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_q[k+1] <= sd_q[k];
				if (x_q[k] >= t) begin
					x_q[k+1] <= x_q[k] - t;
					r_q[k+1] <= (r_q[k] >> 1) + BIT;
				end else begin
					x_q[k+1] <= x_q[k];
					r_q[k+1] <= r_q[k] >> 1;
				end
			end
		end
	end

	assign out_valid = v_q[N];
	assign out_len   = r_q[N][tfn_pkg::LEN_W-1:0];
	assign out_side  = sd_q[N];

endmodule

// File: design/tfn_div.sv
// Pipelined restoring divide of each magnitude by the length, then sign and output register.
module tfn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [tfn_pkg::LEN_W-1:0]  in_len,
	input  tfn_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [3*tfn_pkg::OUT_W-1:0] out_normal,
	output logic                       out_degen,
	output logic                       out_last
);

	localparam int QW = tfn_pkg::Q_W;
	localparam int NW = tfn_pkg::NUM_W;
	localparam int OW = tfn_pkg::OUT_W;

	logic [QW:0]                   v_q;
	logic [NW-1:0]                 rem_q [QW+1][3];
	logic [QW-1:0]                 q_q   [QW+1][3];
	logic [tfn_pkg::LEN_W-1:0]     len_q [QW+1];
	tfn_pkg::side_t                sd_q  [QW+1];
	logic                          v_o;
	logic [OW-1:0]                 n_o [3];
	logic                          dg_o, l_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_q[0] <= in_len;
			sd_q[0]  <= in_side;
			for (int i = 0; i < 3; i++) begin
				rem_q[0][i] <= {in_side.mag[i], {QW-1{1'b0}}} + NW'(in_len >> 1);
				q_q[0][i]   <= '0;
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [NW-1:0] dv;
		assign dv = NW'(len_q[k]) << (QW - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_q[k+1] <= len_q[k];
				sd_q[k+1]  <= sd_q[k];
				for (int i = 0; i < 3; i++) begin
					if (rem_q[k][i] >= dv) begin
						rem_q[k+1][i] <= rem_q[k][i] - dv;
						q_q[k+1][i]   <= q_q[k][i] | (QW'(1) << (QW - 1 - k));
					end else begin
						rem_q[k+1][i] <= rem_q[k][i];
						q_q[k+1][i]   <= q_q[k][i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		if (en) begin
			dg_o <= sd_q[QW].degen;
			l_o  <= sd_q[QW].last;
			for (int i = 0; i < 3; i++) begin
				q = (q_q[QW][i] > tfn_pkg::UNIT_Q14) ? tfn_pkg::UNIT_Q14 : q_q[QW][i];
				if (sd_q[QW].degen) begin
					n_o[i] <= '0;
				end else if (sd_q[QW].neg[i]) begin
					n_o[i] <= -OW'(q);
				end else begin
					n_o[i] <= OW'(q);
				end
			end
		end
	end

	assign out_valid  = v_o;
	assign out_normal = {n_o[2], n_o[1], n_o[0]};
	assign out_degen  = dg_o;
	assign out_last   = l_o;

endmodule

// File: design/triangle_face_normal_core.sv
// Top level of the triangle face normal core.
// Takes one triangle per cycle unless stalled and returns its unit normal (signed
// Q1.14) after 7 stages for edges, cross product, block scaling and squared length,
// 32 stages of square root (one root bit each), 16 stages of division (a load stage,
// then one quotient bit each) and the output register. The whole pipeline holds while
// a result waits on m_tready.
module triangle_face_normal_core #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [3*tfn_pkg::OUT_W-1:0]       m_tdata,  // normal_x normal_y normal_z
	output logic                              m_tuser,  // degenerate
	output logic                              m_tlast
);

	logic                       en;
	logic                       f_valid, r_valid;
	logic [tfn_pkg::SUM_W-1:0]  f_sum;
	tfn_pkg::side_t             f_side, r_side;
	logic [tfn_pkg::LEN_W-1:0]  r_len;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .in_data(s_tdata[9*COORD_WIDTH-1:0]), .in_last(s_tlast),
		.out_valid(f_valid), .out_sum(f_sum), .out_side(f_side)
	);

	tfn_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .in_sum(f_sum), .in_side(f_side),
		.out_valid(r_valid), .out_len(r_len), .out_side(r_side)
	);

	tfn_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(r_valid), .in_len(r_len), .in_side(r_side),
		.out_valid(m_tvalid), .out_normal(m_tdata), .out_degen(m_tuser), .out_last(m_tlast)
	);

endmodule
